// File: rtl/ucg_pkg.sv
// shared types, constants and the tone curve table for the unsharp/tone filter
`default_nettype none

package ucg_pkg;

  localparam int CFG_W       = 11;
  localparam int PIX_W       = 24;
  localparam int CH_W        = 8;
  localparam int UCG_MAX_WIDTH  = 1024;
  localparam int UCG_MAX_HEIGHT = 1024;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = CFG_W'(480);
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = CFG_W'(800);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef logic [PIX_W-1:0] pixel_t;
  // index 0 top, 1 middle, 2 bottom
  typedef logic [2:0][PIX_W-1:0] column_t;

  // one request from the front: the window around one input position
  typedef struct packed {
    column_t win_old;
    column_t win_new;
    column_t cur;
    logic    col1;
    logic    col2;
    logic    last;
    logic    padrow;
  } job_t;

  // contrast, gamma and low-end blend, worked out exactly with integers
  function automatic logic [255:0][7:0] build_tone_lut();
    logic [255:0][7:0] lut;
    logic [127:0]      lhs;
    logic [127:0]      rhs;
    int                w;
    int                lo;
    int                hi;
    int                mid;
    int                e;
    int                v;
    lut = '0;
    for (int i = 0; i < 256; i++) begin
      if (i <= 21) begin
        e = 0;
      end else if (i >= 234) begin
        e = 255;
      end else begin
        w = 3 * i - 64;
        lhs = 128'd1;
        for (int k = 0; k < 9; k++) lhs = lhs * 128'(w);
        lhs = lhs * 128'd255;
        lhs = lhs * 128'd524288;
        lo = 0;
        hi = 255;
        for (int s = 0; s < 9; s++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            rhs = 128'd1;
            for (int k = 0; k < 10; k++) rhs = rhs * 128'(2 * mid - 1);
            rhs = rhs * 128'd1953125;
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
          end
        end
        e = lo;
      end
      if (i < 50) v = (i * (50 - i + e) + 25) / 50;
      else v = e;
      if (v > 255) v = 255;
      lut[i] = 8'(v);
    end
    return lut;
  endfunction

  localparam logic [255:0][7:0] TONE_LUT = build_tone_lut();

endpackage

`default_nettype wire

// File: rtl/ucg_front.sv
// front end: counters, row stores, 3x3 window columns and job generation
`default_nettype none

module ucg_front
  import ucg_pkg::*;
#(
  parameter int MAX_WIDTH  = UCG_MAX_WIDTH,
  parameter int MAX_HEIGHT = UCG_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire reg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  input  wire logic             pad,
  output logic                  job_push,
  output job_t                  job,
  input  wire logic             queue_full
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = ((XW + 1) > CFG_W ? (XW + 1) : CFG_W) + 1;
  localparam int CMPH = (YW > CFG_W ? YW : CFG_W) + 1;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [XW-1:0]    col;
  logic [YW-1:0]    row;

  logic [CMPW-1:0] w_lim;
  logic [CMPH-1:0] h_lim;
  logic            last0;
  logic            padrow0;
  logic            stray;
  logic            in_acc;
  logic            load;

  logic [2*PIX_W-1:0] row_store [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic               byp_hit;
  logic [2*PIX_W-1:0] byp_data;

  logic          s1_valid;
  pixel_t        s1_px;
  logic [XW-1:0] s1_col;
  logic          s1_row_zero;
  logic          s1_pad;
  logic          s1_last;

  logic [2*PIX_W-1:0] mem_word;
  logic [2*PIX_W-1:0] wr_data;
  logic               mem_we;
  column_t            cur;
  column_t            win_new;
  column_t            win_old;
  logic               needs_push;
  logic               s1_adv;

  // clamped frame size
  always_comb begin
    if (image_width == '0) w_lim = CMPW'(1);
    else if (CMPW'(image_width) > CMPW'(MAX_WIDTH)) w_lim = CMPW'(MAX_WIDTH);
    else w_lim = CMPW'(image_width);
    if (image_height == '0) h_lim = CMPH'(1);
    else if (CMPH'(image_height) > CMPH'(MAX_HEIGHT)) h_lim = CMPH'(MAX_HEIGHT);
    else h_lim = CMPH'(image_height);
  end

  assign last0   = CMPW'(col) >= (w_lim - CMPW'(1));
  assign padrow0 = CMPH'(row) >= h_lim;
  // a request with pad set outside the padding row is dropped
  assign stray   = !padrow0 && pad;

  assign needs_push = !s1_row_zero && ((s1_col != '0) || s1_last);
  assign s1_adv     = !needs_push || !queue_full;
  assign in_stall   = s1_valid && !s1_adv;
  assign in_acc     = in_valid && !in_stall;
  assign load       = in_acc && !stray;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (load) begin
        if (last0) begin
          col <= '0;
          row <= padrow0 ? '0 : row + YW'(1);
        end else begin
          col <= col + XW'(1);
        end
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_px       <= {red, green, blue};
      s1_col      <= col;
      s1_row_zero <= (row == '0);
      s1_pad      <= padrow0;
      s1_last     <= last0;
    end
  end

  // row store: {older, newer}; a write to the address being read goes round it
  assign mem_we = s1_valid && s1_adv && !s1_pad;

  always_ff @(posedge clk) begin
    if (mem_we) row_store[s1_col] <= wr_data;
    if (load) begin
      rd_data  <= row_store[col];
      byp_hit  <= mem_we && (s1_col == col);
      byp_data <= wr_data;
    end
  end

  assign mem_word = byp_hit ? byp_data : rd_data;

  always_comb begin
    if (s1_row_zero) begin
      cur[0]  = s1_px;
      cur[1]  = s1_px;
      cur[2]  = s1_px;
      wr_data = {s1_px, s1_px};
    end else begin
      cur[0]  = mem_word[2*PIX_W-1:PIX_W];
      cur[1]  = mem_word[PIX_W-1:0];
      cur[2]  = s1_pad ? mem_word[PIX_W-1:0] : s1_px;
      wr_data = {mem_word[PIX_W-1:0], s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_new <= '0;
      win_old <= '0;
    end else if (s1_valid && s1_adv) begin
      win_old <= win_new;
      win_new <= cur;
    end
  end

  assign job_push    = s1_valid && needs_push && !queue_full;
  assign job.win_old = win_old;
  assign job.win_new = win_new;
  assign job.cur     = cur;
  assign job.col1    = (s1_col != '0);
  assign job.col2    = (s1_col > XW'(1));
  assign job.last    = s1_last;
  assign job.padrow  = s1_pad;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !queue_full)
    else $error("job pushed into a full queue");

  a_row_zero_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_row_zero) |-> !job_push)
    else $error("first row produced a job");

  a_pad_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_pad) |-> !mem_we)
    else $error("padding row wrote the row store");

endmodule

`default_nettype wire

// File: rtl/ucg_queue.sv
// short job queue between front and back
`default_nettype none

module ucg_queue
  import ucg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job,
  input  wire logic pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/ucg_back.sv
// back end: splits jobs into results, box blur, unsharp step and tone lookup
`default_nettype none

module ucg_back
  import ucg_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire job_t            job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic                 frame_end,
  output logic                 burst_end
);

  logic    en;
  logic    issue;
  logic    take_a;
  logic    second;
  column_t l_col;
  column_t c_col;
  column_t r_col;
  logic    res_fe;
  logic    res_be;

  logic [2:0][11:0]     sum;
  logic                 s1_valid;
  logic [2:0][11:0]     s1_sum;
  logic [2:0][CH_W-1:0] s1_orig;
  logic                 s1_fe;
  logic                 s1_be;

  logic [2:0][23:0]        blur_prod;
  logic                    s2_valid;
  logic signed [2:0][8:0]  s2_diff;
  logic [2:0][CH_W-1:0]    s2_orig;
  logic                    s2_fe;
  logic                    s2_be;

  logic [2:0][CH_W-1:0] tone;

  assign en     = !out_valid || !out_stall;
  assign issue  = en && job_valid;
  assign take_a = job.col1 && !second;
  assign job_pop = issue && !(take_a && job.last);

  // pick the window of the result issued this cycle
  always_comb begin
    if (take_a) begin
      l_col  = job.col2 ? job.win_old : job.win_new;
      c_col  = job.win_new;
      r_col  = job.cur;
      res_fe = 1'b0;
      res_be = !job.last;
    end else begin
      l_col  = job.col1 ? job.win_new : job.cur;
      c_col  = job.cur;
      r_col  = job.cur;
      res_fe = job.padrow;
      res_be = 1'b1;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        sum[ch] = sum[ch] + 12'(l_col[k][CH_W*ch +: CH_W])
                          + 12'(c_col[k][CH_W*ch +: CH_W])
                          + 12'(r_col[k][CH_W*ch +: CH_W]);
      end
    end
  end

  // floor(sum / 9) as sum * 3641 >> 15, exact below 2304
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      blur_prod[ch] = 24'(s1_sum[ch]) * 24'd3641;
    end
  end

  // orig + trunc(2 * diff / 5), clamp, then tone curve
  always_comb begin
    logic [CH_W-1:0]   mag;
    logic [16:0]       qprod;
    logic [6:0]        q;
    logic signed [9:0] sharp;
    for (int ch = 0; ch < 3; ch++) begin
      mag   = s2_diff[ch][8] ? 8'(-s2_diff[ch]) : 8'(s2_diff[ch]);
      qprod = 17'({mag, 1'b0}) * 17'd205;
      q     = qprod[16:10];
      if (s2_diff[ch][8]) sharp = $signed({2'b00, s2_orig[ch]}) - $signed({3'b000, q});
      else sharp = $signed({2'b00, s2_orig[ch]}) + $signed({3'b000, q});
      if (sharp < 0) tone[ch] = TONE_LUT[0];
      else if (sharp > 10'sd255) tone[ch] = TONE_LUT[255];
      else tone[ch] = TONE_LUT[sharp[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second    <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) second <= take_a && job.last;
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        s1_sum[ch]  <= sum[ch];
        s1_orig[ch] <= c_col[1][CH_W*ch +: CH_W];
        s2_diff[ch] <= $signed({1'b0, s1_orig[ch]}) - $signed({1'b0, blur_prod[ch][22:15]});
        s2_orig[ch] <= s1_orig[ch];
      end
      s1_fe     <= res_fe;
      s1_be     <= res_be;
      s2_fe     <= s1_fe;
      s2_be     <= s1_be;
      out_red   <= tone[2];
      out_green <= tone[1];
      out_blue  <= tone[0];
      frame_end <= s2_fe;
      burst_end <= s2_be;
    end
  end

  a_second_owner: assert property (@(posedge clk) disable iff (rst)
    second |-> (job_valid && job.col1 && job.last))
    else $error("second result pending without a two-result job");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("pop from an empty queue");

  a_frame_end_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> burst_end)
    else $error("frame end not on the last result of its request");

endmodule

`default_nettype wire

// File: rtl/unsharp_contrast_gamma_filter_unit.sv
// top level of the unsharp mask filter with tone curve
//
// RGB888 pixels enter in raster order, one request per clock while in_stall is
// low, and leave sharpened by a 3x3 unsharp mask and mapped through a fixed
// tone curve; output lags one row and one column, and after each frame the
// source sends one padding row of image_width requests (pad = 1) that flushes
// the last row. The front takes one request every cycle unless it stalls: it
// reads the two row stores (one dual-purpose memory, one read and one write
// port) and builds the window; a four-entry job queue then feeds a three-stage
// arithmetic back end that issues one result per cycle while the output is not
// stalled. A request at the last column of a row wider than one pixel gives
// two results, so over a row the rate stays at one request per clock when the
// output does not stall; the second result of a last-column request follows
// the first from the same queue entry. The row stores are not cleared after
// reset and need no clearing pass.
`default_nettype none

module unsharp_contrast_gamma_filter_unit
  import ucg_pkg::*;
#(
  parameter int MAX_WIDTH  = UCG_MAX_WIDTH,
  parameter int MAX_HEIGHT = UCG_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire reg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  input  wire logic             pad,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic                  frame_end,
  output logic                  burst_end
);

  logic job_push;
  job_t push_job;
  logic queue_full;
  logic head_valid;
  job_t head_job;
  logic job_pop;

  ucg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .pad        (pad),
    .job_push   (job_push),
    .job        (push_job),
    .queue_full (queue_full)
  );

  ucg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (job_pop)
  );

  ucg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end),
    .burst_end (burst_end)
  );

endmodule

`default_nettype wire
